[src/dsmr_pkg.sv]
`timescale 1ns / 1ps

package dsmr_pkg;

  // Line and value limits
  localparam int MAX_LINE    = 1024;
  localparam int VALUE_CHARS = 15;
  localparam int LINE_POS_W  = $clog2(MAX_LINE + 1);
  localparam int CAP_LEN_W   = 5;
  localparam logic [CAP_LEN_W-1:0] CAP_LEN_MAX = '1;

  // Prefix table
  localparam int NPFX        = 21;
  localparam int PFX_MAX_LEN = 11;
  localparam int PFX_POS_W   = $clog2(PFX_MAX_LEN);
  localparam int CODE_W      = 5;
  localparam logic [NPFX-1:0] INT_CODES = 21'h1F0000;

  localparam logic [8*PFX_MAX_LEN-1:0] PFX_TEXT [NPFX] = '{
    "1-0:1.8.1", "1-0:1.8.2", "1-0:2.8.1", "1-0:2.8.2", "1-0:1.7.0",
    "1-0:2.7.0", "1-0:21.7.0", "1-0:41.7.0", "1-0:61.7.0", "1-0:31.7.0",
    "1-0:51.7.0", "1-0:71.7.0", "1-0:32.7.0", "1-0:52.7.0", "1-0:72.7.0",
    "0-1:24.2.1", "0-0:96.14.0", "0-0:96.7.21", "0-0:96.7.9", "1-0:32.32.0",
    "1-0:32.36.0"
  };
  localparam logic [3:0] PFX_LEN [NPFX] = '{
    4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd10, 4'd11, 4'd11
  };

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_0      = "0";
  localparam logic [7:0] CH_9      = "9";

  // CRC-16/ARC
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [2:0]  HEX_DIGITS = 3'd4;

  // Value arithmetic
  localparam int VALUE_W = 63;
  localparam int TERM_W  = 14;
  localparam logic [VALUE_W-1:0] VALUE_MAX   = '1;
  localparam logic [VALUE_W-1:0] MUL10_LIMIT = VALUE_MAX / 10;
  localparam logic [TERM_W-1:0]  DEC_SCALE   = 14'd1000;

  typedef enum logic [2:0] {
    PH_INT   = 3'd0,
    PH_FRAC1 = 3'd1,
    PH_FRAC2 = 3'd2,
    PH_FRAC3 = 3'd3,
    PH_STOP  = 3'd4,
    PH_NUL   = 3'd5,
    PH_BAD   = 3'd6
  } phase_t;

  typedef struct packed {
    logic                pad;
    logic                crc_ok;
    logic                crc_checked;
    logic                value_valid;
    logic [VALUE_W-1:0]  line_value;
    logic [CODE_W-1:0]   line_code;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Bit 4 set when the byte is a hex digit, bits 3..0 its value
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, b[3:0]};
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] pfx_char(input int k, input logic [PFX_POS_W-1:0] pos);
    int sh;
    sh = int'(PFX_LEN[k]) - 1 - int'(pos);
    if (sh < 0) begin
      return 8'h00;
    end
    return PFX_TEXT[k][8*sh +: 8];
  endfunction

endpackage

[src/dsmr_telegram_crc_value_parser.sv]
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// s_*       in   8      request byte: rx_byte
// m_*       out  72     line_code, line_value, value_valid, crc_checked, crc_ok
//
// One byte per cycle sustained while the result side does not stall: a byte is
// registered on input and its CRC, prefix and value update resolves from that register, single pass.
// A newline loads the result register; it can be followed by a byte at once.
// Reset (rst, synchronous) clears the CRC, line and capture state.
// The input stalls only when a newline meets a full, untaken result register.
module dsmr_telegram_crc_value_parser
  import dsmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [4:0] line_code, [67:5] line_value, [68] value_valid,
                                 // [69] crc_checked, [70] crc_ok, [71] zero
);

  // Input stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       is_nl;

  // Telegram and line state
  logic [15:0]           crc_accum, crc_accum_next;
  logic                  crc_running, crc_running_next;
  logic [2:0]            hex_count, hex_count_next;
  logic [15:0]           crc_received, crc_received_next;
  logic                  bang_seen, bang_seen_next;
  logic [LINE_POS_W-1:0] line_pos, line_pos_next;
  logic [NPFX-1:0]       prefix_alive, prefix_alive_next;
  logic [CAP_LEN_W-1:0]  capture_len, capture_len_next;
  logic [VALUE_W-1:0]    capture_accum, capture_accum_next;
  logic                  cap_open, cap_open_next;
  phase_t                cap_phase, cap_phase_next;
  logic [VALUE_W-1:0]    latched_value, latched_value_next;
  logic                  latched_valid, latched_valid_next;

  result_t result;
  logic    out_valid;
  result_t out_data;

  // Datapath helpers
  logic [4:0]        hex;
  logic              int_mode;
  logic [7:0]        end_char;
  logic              is_digit;
  logic [3:0]        digit;
  logic [TERM_W-1:0] term;
  logic [63:0]       add_a;
  logic [63:0]       add_b;
  logic [63:0]       sum;
  logic              over;
  logic              digit_add;

  assign is_nl    = (in_byte == CH_LF);
  assign advance  = in_valid && (!is_nl || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign digit    = in_byte[3:0];
  assign hex      = hex_value(in_byte);

  // Saturating accumulate: ten times the value plus a digit term in the
  // integer phase, value plus a weighted digit in the fraction phases.
  always_comb begin
    unique case (cap_phase)
      PH_FRAC1: term = TERM_W'(digit) * TERM_W'(100);
      PH_FRAC2: term = TERM_W'(digit) * TERM_W'(10);
      PH_FRAC3: term = TERM_W'(digit);
      default:  term = int_mode ? TERM_W'(digit) : TERM_W'(digit) * DEC_SCALE;
    endcase
    if (cap_phase == PH_INT) begin
      add_a = {capture_accum[60:0], 3'b000};
      add_b = {capture_accum[62:0], 1'b0};
      over  = capture_accum > MUL10_LIMIT;
    end else begin
      add_a = {1'b0, capture_accum};
      add_b = 64'd0;
      over  = 1'b0;
    end
    sum = add_a + add_b + 64'(term);
  end

  always_comb begin
    crc_accum_next     = crc_accum;
    crc_running_next   = crc_running;
    hex_count_next     = hex_count;
    crc_received_next  = crc_received;
    bang_seen_next     = bang_seen;
    line_pos_next      = line_pos;
    prefix_alive_next  = prefix_alive;
    capture_len_next   = capture_len;
    capture_accum_next = capture_accum;
    cap_open_next      = cap_open;
    cap_phase_next     = cap_phase;
    latched_value_next = latched_value;
    latched_valid_next = latched_valid;
    result             = '0;
    int_mode           = 1'b0;
    end_char           = CH_STAR;
    digit_add          = 1'b0;

    // CRC and received hex field
    if (in_byte == CH_SLASH) begin
      crc_accum_next    = crc_byte(16'h0000, in_byte);
      crc_running_next  = 1'b1;
      bang_seen_next    = 1'b0;
      hex_count_next    = '0;
      crc_received_next = '0;
    end else begin
      if (bang_seen && hex_count < HEX_DIGITS) begin
        if (hex[4]) begin
          crc_received_next = {crc_received[11:0], hex[3:0]};
          hex_count_next    = hex_count + 3'd1;
        end else begin
          hex_count_next = HEX_DIGITS;
        end
      end
      if (in_byte == CH_BANG) begin
        crc_accum_next    = crc_byte(crc_accum, in_byte);
        crc_running_next  = 1'b0;
        bang_seen_next    = 1'b1;
        hex_count_next    = '0;
        crc_received_next = '0;
      end else if (crc_running) begin
        crc_accum_next = crc_byte(crc_accum, in_byte);
      end
    end

    if (is_nl) begin
      if (line_pos < LINE_POS_W'(MAX_LINE - 1)) begin
        // Lowest matching table entry wins
        for (int k = NPFX - 1; k >= 0; k--) begin
          if (prefix_alive[k] && line_pos >= LINE_POS_W'(PFX_LEN[k])) begin
            result.line_code = CODE_W'(k + 1);
          end
        end
        if (result.line_code != '0 && latched_valid) begin
          result.line_value  = latched_value;
          result.value_valid = 1'b1;
        end
        result.crc_checked = bang_seen_next;
        result.crc_ok      = bang_seen_next && (crc_received_next == crc_accum_next);
      end
      if (bang_seen_next) begin
        crc_accum_next = '0;
      end
      // Start a fresh line
      line_pos_next      = '0;
      prefix_alive_next  = '1;
      capture_len_next   = '0;
      capture_accum_next = '0;
      cap_open_next      = 1'b0;
      cap_phase_next     = PH_INT;
      latched_value_next = '0;
      latched_valid_next = 1'b0;
      bang_seen_next     = 1'b0;
      hex_count_next     = '0;
      crc_received_next  = '0;
    end else begin
      if (line_pos < LINE_POS_W'(PFX_MAX_LEN)) begin
        for (int k = 0; k < NPFX; k++) begin
          if (line_pos < LINE_POS_W'(PFX_LEN[k]) &&
              pfx_char(k, line_pos[PFX_POS_W-1:0]) != in_byte) begin
            prefix_alive_next[k] = 1'b0;
          end
        end
      end
      if (line_pos < LINE_POS_W'(MAX_LINE)) begin
        line_pos_next = line_pos + 1'b1;
      end

      int_mode = |(prefix_alive_next & INT_CODES);
      end_char = int_mode ? CH_RPAREN : CH_STAR;

      if (in_byte == CH_LPAREN) begin
        capture_len_next   = '0;
        capture_accum_next = '0;
        cap_open_next      = 1'b1;
        cap_phase_next     = PH_INT;
        latched_value_next = '0;
        latched_valid_next = 1'b0;
      end else begin
        if (in_byte == end_char) begin
          latched_valid_next = cap_open && cap_phase != PH_BAD && capture_len != '0 &&
                               capture_len <= CAP_LEN_W'(VALUE_CHARS);
          latched_value_next = latched_valid_next ? capture_accum : '0;
        end
        if (capture_len != CAP_LEN_MAX) begin
          capture_len_next = capture_len + 1'b1;
        end
        if (cap_phase != PH_NUL && cap_phase != PH_BAD) begin
          if (in_byte == CH_NUL) begin
            cap_phase_next = PH_NUL;
          end else if (is_digit) begin
            case (cap_phase) inside
              PH_INT: begin
                digit_add = 1'b1;
              end
              PH_FRAC1, PH_FRAC2, PH_FRAC3: begin
                digit_add      = 1'b1;
                cap_phase_next = phase_t'(cap_phase + 3'd1);
              end
              default: begin
              end
            endcase
          end else if (in_byte == CH_DOT) begin
            if (cap_phase == PH_INT && !int_mode) begin
              cap_phase_next = PH_FRAC1;
            end else if (cap_phase < PH_STOP) begin
              cap_phase_next = PH_STOP;
            end
          end else begin
            cap_phase_next = PH_BAD;
          end
          if (digit_add) begin
            capture_accum_next = (over || sum[63]) ? VALUE_MAX : sum[VALUE_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum     <= '0;
      crc_running   <= 1'b0;
      hex_count     <= '0;
      crc_received  <= '0;
      bang_seen     <= 1'b0;
      line_pos      <= '0;
      prefix_alive  <= '1;
      capture_len   <= '0;
      capture_accum <= '0;
      cap_open      <= 1'b0;
      cap_phase     <= PH_INT;
      latched_value <= '0;
      latched_valid <= 1'b0;
    end else if (advance) begin
      crc_accum     <= crc_accum_next;
      crc_running   <= crc_running_next;
      hex_count     <= hex_count_next;
      crc_received  <= crc_received_next;
      bang_seen     <= bang_seen_next;
      line_pos      <= line_pos_next;
      prefix_alive  <= prefix_alive_next;
      capture_len   <= capture_len_next;
      capture_accum <= capture_accum_next;
      cap_open      <= cap_open_next;
      cap_phase     <= cap_phase_next;
      latched_value <= latched_value_next;
      latched_valid <= latched_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_nl) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && is_nl) begin
      out_data <= result;
    end
  end

  a_hex_count_range: assert property (@(posedge clk) disable iff (rst)
    hex_count <= HEX_DIGITS)
    else $error("hex digit count out of range");

  a_bang_stops_crc: assert property (@(posedge clk) disable iff (rst)
    bang_seen |-> !crc_running)
    else $error("telegram end seen while CRC still running");

  a_ok_needs_check: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!out_data.crc_ok || out_data.crc_checked))
    else $error("CRC ok without a checked telegram end");

  a_valid_needs_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!out_data.value_valid || out_data.line_code != '0))
    else $error("valid value on a line with no known code");

  a_line_pos_cap: assert property (@(posedge clk) disable iff (rst)
    line_pos <= LINE_POS_W'(MAX_LINE))
    else $error("line position past its saturation point");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dsmr_pkg::*;

  typedef enum int {
    TAIL_UPPER,
    TAIL_LOWER,
    TAIL_FLIPPED,
    TAIL_SHORT,
    TAIL_JUNK,
    TAIL_NONE
  } crc_tail_t;

  localparam logic [7:0]  CH_CR   = 8'h0D;
  localparam logic [63:0] VAL_CAP = {1'b0, {63{1'b1}}};

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  dsmr_telegram_crc_value_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  string pfx_tab [NPFX] = '{
    "1-0:1.8.1", "1-0:1.8.2", "1-0:2.8.1", "1-0:2.8.2", "1-0:1.7.0",
    "1-0:2.7.0", "1-0:21.7.0", "1-0:41.7.0", "1-0:61.7.0", "1-0:31.7.0",
    "1-0:51.7.0", "1-0:71.7.0", "1-0:32.7.0", "1-0:52.7.0", "1-0:72.7.0",
    "0-1:24.2.1", "0-0:96.14.0", "0-0:96.7.21", "0-0:96.7.9", "1-0:32.32.0",
    "1-0:32.36.0"
  };

  // Shadow copy of the parser state
  logic [15:0]     crc_acc;
  logic            crc_on;
  logic [2:0]      hex_cnt;
  logic [15:0]     crc_rx;
  logic            bang;
  int              line_pos;
  logic [NPFX-1:0] prefix_live;
  int              cap_len;
  logic [63:0]     cap_val;
  logic            cap_open;
  phase_t          cap_ph;
  logic [63:0]     held_val;
  logic            held_ok;

  result_t    line_results [$];
  logic [7:0] line_buf [$];

  bit calm = 1'b0;
  int errors;
  int bytes_sent;
  int lines_seen;
  int valid_values;
  int crc_checks;
  int crc_matches;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    return (a > VAL_CAP - b) ? VAL_CAP : a + b;
  endfunction

  function automatic logic [63:0] sat_mul10(logic [63:0] a);
    return (a > VAL_CAP / 10) ? VAL_CAP : a * 10;
  endfunction

  function automatic void restart_line();
    line_pos    = 0;
    prefix_live = '1;
    cap_len     = 0;
    cap_val     = 64'd0;
    cap_open    = 1'b0;
    cap_ph      = PH_INT;
    held_val    = 64'd0;
    held_ok     = 1'b0;
    bang        = 1'b0;
    hex_cnt     = 3'd0;
    crc_rx      = 16'h0000;
  endfunction

  // Advance the shadow state by one accepted byte; a newline queues a result
  function automatic void track_byte(logic [7:0] b);
    result_t     r;
    int          d;
    bit          hit;
    bit          int_mode;
    bit          ok;
    logic [7:0]  endc;
    logic [63:0] w;
    if (b == CH_SLASH) begin
      crc_acc = crc16_step(16'h0000, b);
      crc_on  = 1'b1;
      bang    = 1'b0;
      hex_cnt = 3'd0;
      crc_rx  = 16'h0000;
    end else begin
      if (bang && hex_cnt < HEX_DIGITS) begin
        d = 16;
        if (b >= CH_0 && b <= CH_9) d = int'(b - CH_0);
        else if (b >= "a" && b <= "f") d = int'(b - "a") + 10;
        else if (b >= "A" && b <= "F") d = int'(b - "A") + 10;
        if (d < 16) begin
          crc_rx = {crc_rx[11:0], d[3:0]};
          hex_cnt++;
        end else begin
          hex_cnt = HEX_DIGITS;
        end
      end
      if (b == CH_BANG) begin
        crc_acc = crc16_step(crc_acc, b);
        crc_on  = 1'b0;
        bang    = 1'b1;
        hex_cnt = 3'd0;
        crc_rx  = 16'h0000;
      end else if (crc_on) begin
        crc_acc = crc16_step(crc_acc, b);
      end
    end

    if (b == CH_LF) begin
      r = '0;
      if (line_pos + 1 < MAX_LINE) begin
        hit = 1'b0;
        for (int k = 0; k < NPFX; k++) begin
          if (!hit && prefix_live[k] && line_pos >= pfx_tab[k].len()) begin
            hit = 1'b1;
            r.line_code = CODE_W'(k + 1);
          end
        end
        if (hit && held_ok) begin
          r.line_value  = held_val[62:0];
          r.value_valid = 1'b1;
          valid_values++;
        end
        r.crc_checked = bang;
        r.crc_ok      = bang && (crc_rx == crc_acc);
      end
      if (r.crc_checked) crc_checks++;
      if (r.crc_ok) crc_matches++;
      if (bang) crc_acc = 16'h0000;
      restart_line();
      line_results.push_back(r);
    end else begin
      if (line_pos < PFX_MAX_LEN) begin
        for (int k = 0; k < NPFX; k++) begin
          if (line_pos < pfx_tab[k].len() && pfx_tab[k].getc(line_pos) != b) begin
            prefix_live[k] = 1'b0;
          end
        end
      end
      if (line_pos < MAX_LINE) line_pos++;

      int_mode = (prefix_live & INT_CODES) != 0;
      endc     = int_mode ? CH_RPAREN : CH_STAR;
      if (b == CH_LPAREN) begin
        cap_len  = 0;
        cap_val  = 64'd0;
        cap_open = 1'b1;
        cap_ph   = PH_INT;
        held_val = 64'd0;
        held_ok  = 1'b0;
      end else begin
        // latch on the end mark, then the mark itself feeds the capture
        if (b == endc) begin
          ok = cap_open && cap_ph != PH_BAD && cap_len >= 1 && cap_len <= VALUE_CHARS;
          held_ok  = ok;
          held_val = ok ? cap_val : 64'd0;
        end
        if (cap_len < 31) cap_len++;
        if (cap_ph != PH_NUL && cap_ph != PH_BAD) begin
          if (b == CH_NUL) begin
            cap_ph = PH_NUL;
          end else if (b >= CH_0 && b <= CH_9) begin
            d = int'(b - CH_0);
            if (cap_ph == PH_INT) begin
              cap_val = sat_add(sat_mul10(cap_val), 64'(int_mode ? d : d * 1000));
            end else if (cap_ph <= PH_FRAC3) begin
              w = 64'((cap_ph == PH_FRAC1) ? 100 : (cap_ph == PH_FRAC2) ? 10 : 1);
              cap_val = sat_add(cap_val, 64'(d) * w);
              cap_ph  = phase_t'(cap_ph + 3'd1);
            end
          end else if (b == CH_DOT) begin
            if (cap_ph == PH_INT && !int_mode) cap_ph = PH_FRAC1;
            else if (cap_ph < PH_STOP) cap_ph = PH_STOP;
          end else begin
            cap_ph = PH_BAD;
          end
        end
      end
    end
  endfunction

  function automatic void flag_field(string name, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch on line %0d, %s: expected 0x%0h, got 0x%0h",
               lines_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (line_results.size() == 0) begin
        flag_field("result with no line pending", 64'd0, 64'(got.line_code));
      end else begin
        want = line_results.pop_front();
        if (got.line_code !== want.line_code)
          flag_field("line_code", 64'(want.line_code), 64'(got.line_code));
        if (got.line_value !== want.line_value)
          flag_field("line_value", 64'(want.line_value), 64'(got.line_value));
        if (got.value_valid !== want.value_valid)
          flag_field("value_valid", 64'(want.value_valid), 64'(got.value_valid));
        if (got.crc_checked !== want.crc_checked)
          flag_field("crc_checked", 64'(want.crc_checked), 64'(got.crc_checked));
        if (got.crc_ok !== want.crc_ok)
          flag_field("crc_ok", 64'(want.crc_ok), 64'(got.crc_ok));
        if (got.pad !== 1'b0)
          flag_field("pad bit", 64'd0, 64'(got.pad));
      end
      lines_seen++;
    end
  end

  // Result side: random stall bursts until the closing stretch
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_buf();
    foreach (line_buf[i]) push_byte(line_buf[i]);
    line_buf.delete();
  endtask

  function automatic void put_ch(logic [7:0] c);
    line_buf.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s.getc(i));
  endfunction

  function automatic void put_digits(int lo, int hi);
    logic [7:0] c;
    repeat ($urandom_range(lo, hi)) begin
      c = CH_0 + 8'($urandom_range(0, 9));
      line_buf.push_back(c);
    end
  endfunction

  // plain: keep out bytes that restart the capture or start or end the telegram
  function automatic void put_noise(int n, bit plain);
    logic [7:0] c;
    repeat (n) begin
      do begin
        c = 8'($urandom_range(0, 255));
      end while (c == CH_LF ||
                 (plain && (c == CH_LPAREN || c == CH_SLASH || c == CH_BANG)));
      line_buf.push_back(c);
    end
  endfunction

  function automatic void put_hex(logic [15:0] v, int n, bit upper);
    logic [3:0] nib;
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      nib = 4'(v >> (12 - 4 * i));
      if (nib < 4'd10) c = CH_0 + 8'(nib);
      else c = (upper ? "A" : "a") + 8'(nib) - 8'd10;
      line_buf.push_back(c);
    end
  endfunction

  function automatic void put_number(bit int_code);
    if (int_code) begin
      put_digits(1, 12);
      if ($urandom_range(0, 3) == 0) begin
        put_ch(CH_DOT);
        put_digits(0, 3);
      end
    end else begin
      put_digits(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        put_ch(CH_DOT);
        put_digits(0, 5);
      end
    end
  endfunction

  // One reading line without its line end; unclean ones carry one defect
  function automatic void make_reading(bit clean);
    int         k;
    int         mode;
    bit         int_code;
    logic [7:0] c;
    k        = $urandom_range(0, NPFX - 1);
    int_code = INT_CODES[k];
    mode     = clean ? 0 : $urandom_range(1, 7);
    if (mode == 7) put_str("1-0:99.97.0");
    else put_str(pfx_tab[k]);
    if (k == 15 && $urandom_range(0, 1) == 1) put_str("(230101120000W)");
    if (mode != 6) put_ch(CH_LPAREN);
    case (mode)
      1: begin
        put_digits(1, 4);
        do begin
          c = 8'($urandom_range(0, 255));
        end while ((c >= CH_0 && c <= CH_9) || c == CH_DOT || c == CH_NUL || c == CH_LF);
        put_ch(c);
        put_digits(0, 4);
      end
      2: begin
        put_digits(1, 6);
        put_ch(CH_NUL);
        put_noise($urandom_range(0, 4), 1'b1);
      end
      3: ;
      4: put_digits(16, 18);
      5: begin
        put_digits(1, 3);
        put_ch(CH_DOT);
        put_digits(1, 3);
        put_ch(CH_DOT);
        put_digits(1, 3);
      end
      default: put_number(int_code);
    endcase
    if ($urandom_range(0, 15) == 0) int_code = !int_code;
    if (int_code) put_ch(CH_RPAREN);
    else put_str("*kWh)");
  endfunction

  task automatic end_line();
    put_ch(CH_CR);
    put_ch(CH_LF);
    send_buf();
  endtask

  // Close the telegram on the current line; the hex field follows the shadow CRC
  task automatic close_telegram(crc_tail_t tail);
    put_ch(CH_BANG);
    send_buf();
    case (tail)
      TAIL_UPPER:   put_hex(crc_acc, 4, 1'b1);
      TAIL_LOWER:   put_hex(crc_acc, 4, 1'b0);
      TAIL_FLIPPED: put_hex(crc_acc ^ (16'h0001 << $urandom_range(0, 15)), 4, 1'b1);
      TAIL_SHORT:   put_hex(crc_acc, 2, 1'b1);
      TAIL_JUNK: begin
        put_hex(crc_acc, 1, 1'b1);
        put_ch("Z");
        put_hex(crc_acc << 4, 3, 1'b1);
      end
      default: ;
    endcase
    end_line();
  endtask

  task automatic send_telegram(int readings, crc_tail_t tail);
    put_str("/ABC5XYZ100-METER");
    end_line();
    end_line();
    repeat (readings) begin
      make_reading($urandom_range(0, 3) != 0);
      end_line();
    end
    close_telegram(tail);
  endtask

  task automatic test_field_extremes();
    for (int k = 0; k < NPFX; k++) begin
      put_str(pfx_tab[k]);
      if (INT_CODES[k]) put_str("(0002)");
      else put_str("(000123.456*kWh)");
      end_line();
    end
    put_str("1-0:1.8.1(99999999999.999*kWh)");
    end_line();
    put_str("1-0:1.8.2(999999999999.999*kWh)");
    end_line();
    put_str("0-0:96.14.0(999999999999999)");
    end_line();
    put_str("0-0:96.7.21(0000000000000000)");
    end_line();
    put_str("1-0:2.8.1(0.000*kWh)");
    end_line();
    put_str("0-0:1.0.0(230101120000W)");
    end_line();
    put_str("1-0:32.36.0");
    put_ch(CH_LF);
    send_buf();
    put_ch(CH_LF);
    send_buf();
    put_str("1-0:1.8.1(");
    put_ch(8'hFF);
    put_ch(8'h80);
    put_ch(8'h7F);
    put_str("*kWh)");
    end_line();
  endtask

  task automatic test_value_rules();
    put_str("1-0:1.7.0(01.2");
    put_ch(CH_NUL);
    put_str("x9*kW)");
    end_line();
    put_str("1-0:2.7.0(01a.234*kW)");
    end_line();
    put_str("1-0:21.7.0(12.3.45*kW)");
    end_line();
    put_str("0-0:96.7.9(00012.9)");
    end_line();
    put_str("1-0:32.7.0(230.12345*V)");
    end_line();
    put_str("0-0:96.14.0()");
    end_line();
    put_str("1-0:31.7.0(*A)");
    end_line();
    put_str("1-0:1.8.2 000123.000*kWh)");
    end_line();
    put_str("1-0:2.8.1(1.0*kWh)(5");
    end_line();
    put_str("0-1:24.2.1(230101120000W)(12785.123*m3)");
    end_line();
    put_str("1-0:2.8.2*5(7");
    end_line();
    put_str("1-0:52.7.0(230.0)");
    end_line();
  endtask

  task automatic test_crc_rules();
    send_telegram(3, TAIL_UPPER);
    send_telegram(2, TAIL_LOWER);
    send_telegram(2, TAIL_FLIPPED);
    send_telegram(1, TAIL_SHORT);
    send_telegram(1, TAIL_NONE);
    send_telegram(1, TAIL_JUNK);
    // restart and end on one line
    put_str("/Q");
    close_telegram(TAIL_UPPER);
    // end mark with no telegram running
    put_str("0-0:96.13.0()");
    close_telegram(TAIL_UPPER);
    // a restart cancels the pending check
    put_str("/METER");
    end_line();
    make_reading(1'b1);
    end_line();
    put_ch(CH_BANG);
    put_str("12/R");
    end_line();
    make_reading(1'b1);
    end_line();
    close_telegram(TAIL_UPPER);
  endtask

  task automatic test_line_length();
    put_str("1-0:1.8.1(000123.456*kWh)");
    put_noise(1021 - line_buf.size(), 1'b1);
    end_line();
    put_str("1-0:1.8.1(000123.456*kWh)");
    put_noise(1022 - line_buf.size(), 1'b1);
    end_line();
    // overlong with a pending check, then a telegram to see the CRC restart clean
    put_str("/M");
    end_line();
    put_str("1-0:2.7.0(00.100*kW)");
    put_ch(CH_BANG);
    put_noise(1100 - line_buf.size(), 1'b1);
    end_line();
    send_telegram(1, TAIL_UPPER);
  endtask

  task automatic test_random_traffic();
    int        start;
    crc_tail_t tail;
    start = bytes_sent;
    while (bytes_sent - start < 1200) begin
      case ($urandom_range(0, 9))
        0: begin
          put_noise($urandom_range(0, 40), 1'b0);
          put_ch(CH_LF);
          send_buf();
        end
        1: repeat ($urandom_range(1, 4)) push_byte(CH_LF);
        2: begin
          make_reading($urandom_range(0, 1) == 1);
          end_line();
        end
        default: begin
          case ($urandom_range(0, 9))
            6: tail = TAIL_LOWER;
            7: tail = TAIL_FLIPPED;
            8: tail = TAIL_SHORT;
            9: tail = ($urandom_range(0, 1) == 1) ? TAIL_JUNK : TAIL_NONE;
            default: tail = TAIL_UPPER;
          endcase
          send_telegram($urandom_range(1, 8), tail);
        end
      endcase
    end
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    repeat (3) send_telegram($urandom_range(2, 5), TAIL_UPPER);
  endtask

  initial begin
    int waited;
    crc_acc = 16'h0000;
    crc_on  = 1'b0;
    restart_line();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_value_rules();
    test_crc_rules();
    test_line_length();
    test_random_traffic();
    test_steady_stream();
    s_tvalid <= 1'b0;

    waited = 0;
    while (line_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (line_results.size() != 0) begin
      errors += line_results.size();
      $display("%0d line results never arrived", line_results.size());
    end

    $display("summary: %0d bytes fed, %0d lines checked, %0d with a valid value",
             bytes_sent, lines_seen, valid_values);
    $display("summary: %0d telegram ends checked, %0d with a matching crc",
             crc_checks, crc_matches);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
